/* rtl/core/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int WIN_SLOTS       = 8;
    localparam int DEF_MAX_PATTERN = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int REP_CAP         = (MAX_REPLACEMENT < WIN_SLOTS) ? MAX_REPLACEMENT : WIN_SLOTS;
    localparam int REP_IDX_W       = (REP_CAP > 1) ? $clog2(REP_CAP) : 1;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_BYTES = 2'd0,
        CFG_PAT_LEN   = 2'd1,
        CFG_REP_BYTES = 2'd2,
        CFG_REP_LEN   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_REPL,
        S_DRAIN,
        S_MARK
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

/* rtl/core/sfr_cell.sv */
// One window cell: holds a text byte, shifts towards its neighbour and compares with the pattern.
module sfr_cell (
    input  logic                     i_clk,
    input  sfr_pkg::t_cell_ctl       i_ctl,
    input  logic [sfr_pkg::BYTE_W-1:0] i_text_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_next_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_pat_byte,
    output logic [sfr_pkg::BYTE_W-1:0] o_byte,
    output logic                     o_match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] w_view;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_text_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_next_byte;
        end
    end

    // The comparison sees the byte being loaded in this cycle.
    assign w_view  = i_ctl.load ? i_text_byte : r_byte;
    assign o_match = (w_view == i_pat_byte);
    assign o_byte  = r_byte;

endmodule

/* rtl/core/stream_find_and_replace.sv */
// Top level of the stream find-and-replace block: configuration, cell chain and sequencer.
// An item with no result keeps the sequencer idle; an item with k results has all k loaded in turn.
// The sequencer loads one result per cycle into the output register while that register is free.
// An item's first result goes from the sequencer state to the output register and waits for ready.
// Synchronous active-low reset clears the sequencer, window fill, output valid and all registers
// of the configuration port; the window bytes themselves are not cleared.
module stream_find_and_replace #(
    parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_final_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_run_end,
    output logic                          o_text_end,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfr_pkg::*;

    localparam int NUM_CELLS = (MAX_PATTERN < WIN_SLOTS) ? MAX_PATTERN : WIN_SLOTS;
    localparam int FILL_W    = $clog2(NUM_CELLS + 1);

    logic [CFG_DATA_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]      r_pat_len;
    logic [CFG_DATA_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0]      r_rep_len;

    t_state                r_state;
    t_state                n_state;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic [REP_IDX_W-1:0]  r_cnt;
    logic [REP_IDX_W-1:0]  n_cnt;
    logic [BYTE_W-1:0]     r_byte;
    logic                  r_final;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_bvalid;
    logic                  r_out_last;
    logic                  r_out_tend;

    logic [LEN_W-1:0]      w_plen_full;
    logic [FILL_W-1:0]     w_plen;
    logic [LEN_W-1:0]      w_rlen;
    logic [FILL_W-1:0]     w_fe;
    logic [FILL_W-1:0]     w_new_fill;
    logic                  w_full;
    logic                  w_match;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_cnt_last;
    logic                  w_drain_one;
    logic                  w_plen_zero;

    logic                  w_emit;
    logic [BYTE_W-1:0]     w_emit_byte;
    logic                  w_emit_bvalid;
    logic                  w_emit_last;
    logic                  w_emit_tend;
    logic                  w_shift;
    logic                  w_load_en;

    logic [NUM_CELLS-1:0]  w_eq;
    logic [NUM_CELLS-1:0]  w_active;
    logic [BYTE_W-1:0]     w_chain [NUM_CELLS+1];
    t_cell_ctl             w_ctl   [NUM_CELLS];

    // Effective lengths are limited to what the window and the replacement store can hold.
    assign w_plen_full = (r_pat_len > LEN_W'(NUM_CELLS)) ? LEN_W'(NUM_CELLS) : r_pat_len;
    assign w_plen      = w_plen_full[FILL_W-1:0];
    assign w_rlen      = (r_rep_len > LEN_W'(REP_CAP)) ? LEN_W'(REP_CAP) : r_rep_len;
    assign w_plen_zero = (w_plen == '0);

    assign w_fe       = (r_fill >= w_plen) ? '0 : r_fill;
    assign w_new_fill = w_fe + FILL_W'(1);
    assign w_full     = (w_new_fill == w_plen);
    assign w_match    = &(w_eq | ~w_active);

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load_en   = w_accept && !w_plen_zero;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_cnt_last  = (LEN_W'(r_cnt) == (w_rlen - LEN_W'(1)));
    assign w_drain_one = (r_fill == FILL_W'(1));

    assign w_chain[NUM_CELLS] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        assign w_active[g]    = (FILL_W'(g) < w_plen);
        assign w_ctl[g].load  = w_load_en && (w_fe == FILL_W'(g));
        assign w_ctl[g].shift = w_shift;

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_text_byte (i_text_byte),
            .i_next_byte (w_chain[g+1]),
            .i_pat_byte  (r_pat_bytes[g*BYTE_W +: BYTE_W]),
            .o_byte      (w_chain[g]),
            .o_match     (w_eq[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_plen_zero) begin
                        n_state = S_PASS;
                    end else if (w_full && w_match) begin
                        if (w_rlen != '0) begin
                            n_state = S_REPL;
                        end else if (i_final_byte) begin
                            n_state = S_MARK;
                        end
                    end else if (w_full || i_final_byte) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_PASS, S_MARK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_REPL: begin
                if (w_out_free && w_cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_out_free && (!r_final || w_drain_one)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_emit        = 1'b0;
        w_emit_byte   = '0;
        w_emit_bvalid = 1'b0;
        w_emit_last   = 1'b0;
        w_emit_tend   = 1'b0;
        w_shift       = 1'b0;
        n_fill        = r_fill;
        n_cnt         = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_load_en) begin
                    n_fill = (w_full && w_match) ? '0 : w_new_fill;
                end
            end
            S_PASS: begin
                w_emit        = 1'b1;
                w_emit_byte   = r_byte;
                w_emit_bvalid = 1'b1;
                w_emit_last   = 1'b1;
                w_emit_tend   = r_final;
            end
            S_REPL: begin
                w_emit        = 1'b1;
                w_emit_byte   = r_rep_bytes[r_cnt*BYTE_W +: BYTE_W];
                w_emit_bvalid = 1'b1;
                w_emit_last   = w_cnt_last;
                w_emit_tend   = w_cnt_last && r_final;
                if (w_out_free) begin
                    n_cnt = r_cnt + REP_IDX_W'(1);
                end
            end
            S_DRAIN: begin
                w_emit        = 1'b1;
                w_emit_byte   = w_chain[0];
                w_emit_bvalid = 1'b1;
                w_emit_last   = !r_final || w_drain_one;
                w_emit_tend   = r_final && w_drain_one;
                if (w_out_free) begin
                    w_shift = 1'b1;
                    n_fill  = r_fill - FILL_W'(1);
                end
            end
            S_MARK: begin
                w_emit        = 1'b1;
                w_emit_last   = 1'b1;
                w_emit_tend   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_PAT_BYTES: r_pat_bytes <= i_cfg_data;
                    CFG_PAT_LEN: begin
                        r_pat_len <= i_cfg_data[LEN_W-1:0];
                        r_fill    <= '0;
                    end
                    CFG_REP_BYTES: r_rep_bytes <= i_cfg_data;
                    CFG_REP_LEN:   r_rep_len   <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (w_accept) begin
            r_byte  <= i_text_byte;
            r_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_out_free) begin
            r_out_byte   <= w_emit_byte;
            r_out_bvalid <= w_emit_bvalid;
            r_out_last   <= w_emit_last;
            r_out_tend   <= w_emit_tend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_run_end    = r_out_last;
    assign o_text_end   = r_out_tend;

    a_bare_mark_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_run_end && o_text_end))
        else $error("A bare end mark must close both the run and the text.");

    a_text_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_end) |-> o_run_end)
        else $error("The end of the text must also end the run.");

    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && w_out_free) |=> o_out_valid)
        else $error("A result loaded by the sequencer must be offered for transfer.");

endmodule
